// ===== hdl/qacs_pkg.sv =====
`timescale 1ns / 1ps
package qacs_pkg;

  // Extra fraction bits carried by the vector during the micro-rotations.
  localparam int unsigned GUARD_BITS = 24;
  localparam int unsigned SCALE_BITS = 16;
  localparam int unsigned CODE_BITS  = 16;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd360;

  typedef struct packed {
    logic valid;
    logic hold;   // angle already final, micro-rotations leave it alone
  } qacs_ctrl_t;

  // atan(2^-i) / (2*pi), 32 fraction bits of a turn, round to nearest
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Table entry rounded half up to frac_bits fraction bits of a turn.
  function automatic logic [31:0] turn_step(input int unsigned step,
                                            input int unsigned frac_bits);
    logic [32:0]  t;
    int unsigned  sh;
    t  = {1'b0, ATAN_TURN32[step[4:0]]};
    sh = 32 - frac_bits;
    if (sh == 0) begin
      return t[31:0];
    end
    t = (t + (33'd1 << (sh - 1))) >> sh;
    return t[31:0];
  endfunction

endpackage

// ===== hdl/qacs_pre.sv =====
`timescale 1ns / 1ps
module qacs_pre import qacs_pkg::*; #(
  parameter int unsigned INPUT_BITS = 16,
  parameter int unsigned AW         = 24,
  parameter int unsigned VW         = INPUT_BITS + GUARD_BITS + 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [INPUT_BITS-1:0] cos_i,
  input  logic signed [INPUT_BITS-1:0] sin_i,
  output qacs_ctrl_t                   ctrl_o,
  output logic signed [VW-1:0]         x_o,
  output logic signed [VW-1:0]         y_o,
  output logic        [AW-1:0]         z_o
);

  localparam logic [AW-1:0] HALF_TURN    = {1'b1, {(AW-1){1'b0}}};
  localparam logic [AW-1:0] QUARTER_TURN = {2'b01, {(AW-2){1'b0}}};
  localparam logic [AW-1:0] THREEQ_TURN  = {2'b11, {(AW-2){1'b0}}};

  qacs_ctrl_t           ctrl_d, ctrl_q;
  logic signed [VW-1:0] x_d, x_q, y_d, y_q, cx, sy;
  logic        [AW-1:0] z_d, z_q;

  always_comb begin
    cx = {{(VW-INPUT_BITS){cos_i[INPUT_BITS-1]}}, cos_i} <<< GUARD_BITS;
    sy = {{(VW-INPUT_BITS){sin_i[INPUT_BITS-1]}}, sin_i} <<< GUARD_BITS;
    ctrl_d.valid = valid_i;
    ctrl_d.hold  = 1'b0;
    x_d = cx;
    y_d = sy;
    z_d = '0;
    if (cos_i == '0) begin
      ctrl_d.hold = 1'b1;
      z_d = sin_i[INPUT_BITS-1] ? THREEQ_TURN : QUARTER_TURN;
    end else if (sin_i == '0) begin
      ctrl_d.hold = 1'b1;
      z_d = cos_i[INPUT_BITS-1] ? HALF_TURN : '0;
    end else if (cos_i[INPUT_BITS-1]) begin
      // left half plane: turn by half a turn first
      x_d = -cx;
      y_d = -sy;
      z_d = HALF_TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== hdl/qacs_cordic_stage.sv =====
`timescale 1ns / 1ps
module qacs_cordic_stage import qacs_pkg::*; #(
  parameter int unsigned VW   = 43,
  parameter int unsigned AW   = 24,
  parameter int unsigned STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qacs_ctrl_t           ctrl_i,
  input  logic signed [VW-1:0] x_i,
  input  logic signed [VW-1:0] y_i,
  input  logic        [AW-1:0] z_i,
  output qacs_ctrl_t           ctrl_o,
  output logic signed [VW-1:0] x_o,
  output logic signed [VW-1:0] y_o,
  output logic        [AW-1:0] z_o
);

  localparam logic [AW-1:0] TURN_INC = AW'(turn_step(STEP, AW));

  qacs_ctrl_t           ctrl_q;
  logic signed [VW-1:0] xs, ys, x_d, x_q, y_d, y_q;
  logic        [AW-1:0] z_d, z_q;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!y_i[VW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + TURN_INC;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - TURN_INC;
    end
    if (ctrl_i.hold) begin
      z_d = z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== hdl/qacs_post.sv =====
`timescale 1ns / 1ps
module qacs_post import qacs_pkg::*; #(
  parameter int unsigned AW = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qacs_ctrl_t            ctrl_i,
  input  logic [AW-1:0]         z_i,
  input  logic [SCALE_BITS-1:0] scale_i,
  output logic                  done_o,
  output logic [CODE_BITS-1:0]  code_o
);

  localparam int unsigned PW = AW + SCALE_BITS;
  localparam logic [AW-1:0] HALF_STEP = {1'b1, {(AW-1){1'b0}}};

  logic                 prod_vld_q, done_q;
  logic [PW-1:0]        prod_q;
  logic [CODE_BITS:0]   code_sum;
  logic [CODE_BITS-1:0] code_d, code_q;

  always_comb begin
    code_sum = {1'b0, prod_q[PW-1:AW]} + {{CODE_BITS{1'b0}}, (prod_q[AW-1:0] > HALF_STEP)};
    code_d   = code_sum[CODE_BITS] ? {CODE_BITS{1'b1}} : code_sum[CODE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.valid;
      done_q     <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(z_i) * PW'(scale_i);
    code_q <= code_d;
  end

  assign done_o = done_q;
  assign code_o = code_q;

endmodule

// ===== hdl/quadrant_angle_to_scaled_code_top.sv =====
`timescale 1ns / 1ps
// Angle of a (cosine, sine) pair as a code in scale steps per turn.
//
// Input: drive cosine_component_i / sine_component_i with start_i high; the
// beat is taken on any edge where start_i is high and busy_o is low. busy_o
// is always low, so a new pair may be offered every cycle.
// Output: angle_code_o is valid for one cycle while done_o is high; the
// receiver has no back-pressure and must take every beat as it comes.
// Pipeline: done_o and the code are registered after one stage for the input
// correction, one per micro-rotation, one for the scale multiply and one for
// rounding. Throughput is one pair per clock.
// Configuration: cfg_we_i writes cfg_wdata_i into the scale register. Write
// only while no beat is in flight; the scale is sampled at the multiply.
// Reset: rst_ni clears all valid bits (nothing in flight, done_o low) and
// sets the scale to 360.
module quadrant_angle_to_scaled_code_top import qacs_pkg::*; #(
  parameter int unsigned INPUT_BITS         = 16,
  parameter int unsigned TURN_FRACTION_BITS = 24,
  parameter int unsigned CORDIC_STEPS       = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [INPUT_BITS-1:0] cosine_component_i,
  input  logic signed [INPUT_BITS-1:0] sine_component_i,
  output logic                         done_o,
  output logic [CODE_BITS-1:0]         angle_code_o,
  input  logic                         cfg_we_i,
  input  logic [SCALE_BITS-1:0]        cfg_wdata_i
);

  localparam int unsigned AW = TURN_FRACTION_BITS;
  localparam int unsigned VW = INPUT_BITS + GUARD_BITS + 3;

  logic [SCALE_BITS-1:0] scale_q;

  qacs_ctrl_t           ctrl_s [CORDIC_STEPS+1];
  logic signed [VW-1:0] x_s    [CORDIC_STEPS+1];
  logic signed [VW-1:0] y_s    [CORDIC_STEPS+1];
  logic        [AW-1:0] z_s    [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  qacs_pre #(
    .INPUT_BITS (INPUT_BITS),
    .AW         (AW),
    .VW         (VW)
  ) u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .cos_i   (cosine_component_i),
    .sin_i   (sine_component_i),
    .ctrl_o  (ctrl_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .z_o     (z_s[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    qacs_cordic_stage #(
      .VW   (VW),
      .AW   (AW),
      .STEP (i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_s[i]),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1])
    );
  end

  qacs_post #(
    .AW (AW)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_s[CORDIC_STEPS]),
    .z_i     (z_s[CORDIC_STEPS]),
    .scale_i (scale_q),
    .done_o  (done_o),
    .code_o  (angle_code_o)
  );

endmodule
